/* rtl/rfpd_pkg.sv */
// ----------------------------------------------------------------------------
// rfpd_pkg: shared types and constants for the rf power sample to dbm core
// fixed field widths, calibration limits, register indexes and fsm states
// ----------------------------------------------------------------------------
package rfpd_pkg;

  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned READING_W   = 16;
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  // 1024 * slope as a divisor
  localparam int unsigned SLOPE_SHIFT = 10;
  localparam int unsigned DEN_W       = CFG_W + SLOPE_SHIFT;
  // millivolts = avg * ref_mv / 1024
  localparam int unsigned RAW_SHIFT   = 10;
  localparam int unsigned MILLI       = 1000;

  localparam logic [CFG_W-1:0] SLOPE_MIN = 8'd160;
  localparam logic [CFG_W-1:0] SLOPE_MAX = 8'd180;
  localparam logic [CFG_W-1:0] SLOPE_DEF = 8'd173;
  localparam logic [CFG_W-1:0] ICPT_MIN  = 8'd65;
  localparam logic [CFG_W-1:0] ICPT_MAX  = 8'd75;
  localparam logic [CFG_W-1:0] ICPT_DEF  = 8'd68;
  localparam logic             RAW_DEF   = 1'b0;

  localparam logic [READING_W-1:0] CENTI      = 16'd100;
  localparam logic [READING_W-1:0] DBM_OFFSET = 16'd1995;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOPE     = 2'd0,
    CFG_INTERCEPT = 2'd1,
    CFG_RAW_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_AVG,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* rtl/rfpd_sample_if.sv */
// ----------------------------------------------------------------------------
// rfpd_sample_if: input channel carrying one adc conversion per item
// valid/ready handshake, item moves when both are high
// ----------------------------------------------------------------------------
interface rfpd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [rfpd_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* rtl/rfpd_reading_if.sv */
// ----------------------------------------------------------------------------
// rfpd_reading_if: output channel carrying one power reading per item
// valid/ready handshake, item moves when both are high
// ----------------------------------------------------------------------------
interface rfpd_reading_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rfpd_pkg::READING_W-1:0] reading;
  logic                                  reading_is_raw;

  modport source (output valid, output reading, output reading_is_raw, input ready);
  modport sink (input valid, input reading, input reading_is_raw, output ready);
endinterface

/* rtl/rfpd_serial_div.sv */
// ----------------------------------------------------------------------------
// rfpd_serial_div: restoring divider, one quotient bit per cycle
// loads on start, steps through every dividend bit, pulses done with the quotient held
// ----------------------------------------------------------------------------
module rfpd_serial_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 18
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [DEN_W-1:0]          den_i,
  output logic [NUM_W-1:0]          quot_o,
  output rfpd_pkg::div_status_t     status_o
);
  import rfpd_pkg::*;

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], qbit};
      rem_d = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o        = num_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

/* rtl/rf_power_sample_to_dbm_core.sv */
// ----------------------------------------------------------------------------
// rf_power_sample_to_dbm_core: windowed log-detector average to mV or centi-dBm
// throughput: one sample item per cycle inside a window; the item that closes
//   a window holds the input off until the result is computed and taken into the output register
// after a window ends the serial divider (one bit a cycle) forms the average,
//   the shift-add multiplier (one bit a cycle) scales it, and in dbm mode the
//   divider runs again for the quotient by 1024 * slope (PROD_W = 32 at 3300 mV)
// reset: sum, count, fsm and output valid clear; cal regs go to 173, 68, raw 0
// ----------------------------------------------------------------------------
module rf_power_sample_to_dbm_core #(
  parameter int unsigned AVG_SAMPLES = 16,
  parameter int unsigned REF_MV      = 3300
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rfpd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rfpd_pkg::CFG_W-1:0]         cfg_wdata_i,
  rfpd_sample_if.sink                        sample_i,
  rfpd_reading_if.source                     reading_o
);
  import rfpd_pkg::*;

  // window counter wide enough to hold the window length
  localparam int unsigned CNT_W = $clog2(AVG_SAMPLES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_SAMPLES - 1);

  // largest product avg * ref_mv * 1000 sets the datapath width
  localparam longint unsigned AVG_MAX = (64'd1 << SAMPLE_W) - 64'd1;
  localparam longint unsigned NUM_MAX = AVG_MAX * REF_MV * MILLI;
  localparam int unsigned     PROD_W  = $clog2(NUM_MAX + 64'd1);

  localparam logic [PROD_W-1:0] K_RAW = PROD_W'(REF_MV);
  localparam logic [PROD_W-1:0] K_DBM = PROD_W'(64'(REF_MV) * MILLI);

  localparam int unsigned MUL_CNT_W = $clog2(SAMPLE_W);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(SAMPLE_W - 1);

  localparam logic [DEN_W-1:0] AVG_DEN = DEN_W'(AVG_SAMPLES);

  // calibration registers
  logic [CFG_W-1:0] slope_q;
  logic [CFG_W-1:0] icpt_q;
  logic             raw_q;

  // window accumulation
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // fsm and datapath
  state_e               state_q, state_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [SAMPLE_W-1:0]  mplier_q, mplier_d;
  logic [MUL_CNT_W-1:0] mul_cnt_q, mul_cnt_d;
  logic [READING_W-1:0] res_q, res_d;

  // output register, parts the compute side from the consumer
  logic                 out_valid_q, out_valid_d;
  logic [READING_W-1:0] out_res_q, out_res_d;
  logic                 out_raw_q, out_raw_d;

  // shared divider
  logic              div_start;
  logic [PROD_W-1:0] div_num;
  logic [DEN_W-1:0]  div_den;
  logic [PROD_W-1:0] div_quot;
  div_status_t       div_st;

  logic             in_acc;
  logic             window_end;
  logic [CFG_W-1:0] eff_slope;
  logic [CFG_W-1:0] eff_icpt;
  logic             out_free;

  // out-of-range calibration falls back to the nominal detector values
  assign eff_slope = (slope_q < SLOPE_MIN || slope_q > SLOPE_MAX) ? SLOPE_DEF : slope_q;
  assign eff_icpt  = (icpt_q < ICPT_MIN || icpt_q > ICPT_MAX) ? ICPT_DEF : icpt_q;

  assign sample_i.ready = (state_q == ST_ACC);
  assign in_acc         = sample_i.valid && sample_i.ready;
  assign window_end     = in_acc && (cnt_q == LAST_CNT);
  assign out_free       = !out_valid_q || reading_o.ready;

  // config writes, bits above each register width dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q <= SLOPE_DEF;
      icpt_q  <= ICPT_DEF;
      raw_q   <= RAW_DEF;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SLOPE:     slope_q <= cfg_wdata_i;
        CFG_INTERCEPT: icpt_q  <= cfg_wdata_i;
        CFG_RAW_MODE:  raw_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    mul_cnt_d   = mul_cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_raw_d   = out_raw_q;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = AVG_DEN;

    // consumer took the pending result
    if (out_valid_q && reading_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_ACC: begin
        if (in_acc) begin
          sum_d = sum_q + SUM_W'(sample_i.sample);
          cnt_d = cnt_q + 1'b1;
          if (window_end) begin
            // truncated average of the closed window
            div_start = 1'b1;
            div_num   = PROD_W'(sum_d);
            div_den   = AVG_DEN;
            sum_d     = '0;
            cnt_d     = '0;
            state_d   = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        if (div_st.done) begin
          acc_d     = '0;
          mcand_d   = raw_q ? K_RAW : K_DBM;
          mplier_d  = div_quot[SAMPLE_W-1:0];
          mul_cnt_d = '0;
          state_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        // shift-add, one average bit per cycle
        acc_d     = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
        mcand_d   = {mcand_q[PROD_W-2:0], 1'b0};
        mplier_d  = {1'b0, mplier_q[SAMPLE_W-1:1]};
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (mul_cnt_q == MUL_LAST) begin
          if (raw_q) begin
            res_d   = READING_W'(acc_d >> RAW_SHIFT);
            state_d = ST_OUT;
          end else begin
            // quotient by 1024 * slope
            div_start = 1'b1;
            div_num   = acc_d;
            div_den   = DEN_W'({eff_slope, {SLOPE_SHIFT{1'b0}}});
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          // offsets are exact, sum wraps to the 16-bit reading
          res_d   = div_quot[READING_W-1:0]
                    - READING_W'({8'd0, eff_icpt} * CENTI) + DBM_OFFSET;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_raw_d   = raw_q;
          state_d     = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      sum_q       <= '0;
      cnt_q       <= '0;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      mul_cnt_q   <= mul_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
    out_raw_q <= out_raw_d;
  end

  rfpd_serial_div #(
    .NUM_W (PROD_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .quot_o   (div_quot),
    .status_o (div_st)
  );

  assign reading_o.valid          = out_valid_q;
  assign reading_o.reading        = $signed(out_res_q);
  assign reading_o.reading_is_raw = out_raw_q;

  // the item that closes a window always starts the average
  a_window_starts_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_end |=> (state_q == ST_AVG && div_st.busy))
    else $error("window end did not start the average divide");

  // divider only runs for the average or the dbm quotient
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st.busy || div_st.done) |-> (state_q == ST_AVG || state_q == ST_DIV))
    else $error("divider active outside a divide state");

  // window count stays below the window length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_CNT)
    else $error("sample count past window length");

  // millivolt readings are never negative
  a_raw_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_free && raw_q) |=> !out_res_q[READING_W-1])
    else $error("negative millivolt reading");

endmodule

/* verif/rf_power_sample_to_dbm_core_test.sv */
// ----------------------------------------------------------------------------
// rf_power_sample_to_dbm_core_test: self-checking bench for the power core
// drives adc sample items through the valid/ready channel, keeps its own
// model of the window average and the mv / centi-dbm conversion, and checks
// each reading item against the oldest predicted one; calibration settings
// are swept between phases, with random gaps and a long receiver hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rf_power_sample_to_dbm_core_test;
  import rfpd_pkg::*;

  localparam int unsigned WINDOW_LEN   = 16;
  localparam int unsigned REF_MILLIVOLT = 3300;
  // write to the one index that no register occupies
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // settle time covers the worst case dbm conversion, with margin
  localparam int SETTLE_CYCLES  = 120;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int QUIET_LIMIT    = 6000;
  localparam int RANDOM_ITEMS   = 80;

  typedef struct packed {
    logic signed [READING_W-1:0] reading;
    logic                        is_raw;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  rfpd_sample_if  sample_ch ();
  rfpd_reading_if reading_ch ();

  rf_power_sample_to_dbm_core #(
    .AVG_SAMPLES (WINDOW_LEN),
    .REF_MV      (REF_MILLIVOLT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_ch),
    .reading_o   (reading_ch)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // known values on every input before reset releases
  initial begin
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    reading_ch.ready = 1'b0;
  end

  // ---- predictor state: calibration copy and window accumulator ----------
  logic [CFG_W-1:0] cal_slope     = SLOPE_DEF;
  logic [CFG_W-1:0] cal_intercept = ICPT_DEF;
  logic             cal_raw       = RAW_DEF;
  logic [SUM_W-1:0] window_sum    = '0;
  int unsigned      window_fill   = 0;

  reading_t expected_readings[$];

  int  error_count  = 0;
  int  hold_request = 0;
  bit  src_gaps_on  = 1'b1;
  bit  sink_gaps_on = 1'b1;
  int  quiet_cycles = 0;

  // most gaps are zero or short, a few run long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // fold one sample into the window; at the window end form the reading
  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] value);
    longint unsigned avg;
    longint unsigned num;
    longint unsigned den;
    int              level;
    logic [CFG_W-1:0] slope_used;
    logic [CFG_W-1:0] icpt_used;
    reading_t        r;
    window_sum  = window_sum + SUM_W'(value);
    window_fill = window_fill + 1;
    if (window_fill < WINDOW_LEN) return;

    avg         = longint'(window_sum) / WINDOW_LEN;
    window_sum  = '0;
    window_fill = 0;

    if (cal_raw) begin
      level = int'((avg * REF_MILLIVOLT) >> RAW_SHIFT);
    end else begin
      // out of range calibration falls back to the default value
      slope_used = (cal_slope < SLOPE_MIN || cal_slope > SLOPE_MAX) ? SLOPE_DEF : cal_slope;
      icpt_used  = (cal_intercept < ICPT_MIN || cal_intercept > ICPT_MAX) ?
                   ICPT_DEF : cal_intercept;
      num   = avg * REF_MILLIVOLT * MILLI;
      den   = longint'(slope_used) << SLOPE_SHIFT;
      level = int'(num / den) - int'(CENTI) * int'(icpt_used) + int'(DBM_OFFSET);
    end
    r.reading = level[READING_W-1:0];
    r.is_raw  = cal_raw;
    expected_readings.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
    error_count++;
  endtask

  // compare one accepted reading item with the oldest prediction
  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch("reading with nothing pending", int'(reading_ch.reading), 0);
      return;
    end
    want = expected_readings.pop_front();
    if (reading_ch.reading !== want.reading)
      report_mismatch("reading", int'(reading_ch.reading), int'(want.reading));
    if (reading_ch.reading_is_raw !== want.is_raw)
      report_mismatch("reading_is_raw", int'(reading_ch.reading_is_raw), int'(want.is_raw));
  endtask

  // ---- receiver: checks items, drives ready with gaps and hold-offs ------
  initial begin : reading_sink
    int stall;
    int gap;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (reading_ch.valid && reading_ch.ready) check_reading();
      // long hold-off is counted here, independent of the sender
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        reading_ch.ready <= 1'b0;
        stall--;
      end else if (sink_gaps_on) begin
        gap = pick_gap();
        if (gap > 0) begin
          reading_ch.ready <= 1'b0;
          stall = gap - 1;
        end else begin
          reading_ch.ready <= 1'b1;
        end
      end else begin
        reading_ch.ready <= 1'b1;
      end
    end
  end

  // ---- watchdog: too long with no item moving on either side -------------
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (reading_ch.valid && reading_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---- sender side -------------------------------------------------------
  // offers one sample item; valid stays up when the next item follows at once
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int gap;
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= value;
    do @(posedge clk_i); while (!sample_ch.ready);
    accumulate_sample(value);
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // a run of samples around a random level, with outliers at the rails and anywhere in range
  task automatic send_level_run(input int count);
    int level;
    int spread;
    int v;
    int r;
    level  = $urandom_range(0, 1023);
    spread = $urandom_range(0, 64);
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r == 0)      v = 0;
      else if (r == 1) v = 1023;
      else if (r < 5)  v = $urandom_range(0, 1023);
      else begin
        v = level + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      send_sample(SAMPLE_W'(v));
    end
  endtask

  // stop offering, wait for every pending reading, then let the core settle
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one register write, only called while the core is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SLOPE:     cal_slope     = data;
      CFG_INTERCEPT: cal_intercept = data;
      CFG_RAW_MODE:  cal_raw       = data[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random calibration, about half in range, raw bit with junk upper bits
  task automatic randomize_settings();
    if ($urandom_range(0, 1)) write_reg(CFG_SLOPE, CFG_W'($urandom_range(160, 180)));
    else                      write_reg(CFG_SLOPE, CFG_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) write_reg(CFG_INTERCEPT, CFG_W'($urandom_range(65, 75)));
    else                      write_reg(CFG_INTERCEPT, CFG_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_RAW_MODE, CFG_W'({$urandom_range(0, 127), 1'b1}));
    else
      write_reg(CFG_RAW_MODE, CFG_W'({$urandom_range(0, 127), 1'b0}));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 255)));
  endtask

  // ---- tests -------------------------------------------------------------
  task automatic apply_reset();
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // reset calibration, rail samples, both modes, raw mode changed mid-window
  task automatic test_directed_windows();
    repeat (WINDOW_LEN) send_sample(10'd1023);
    repeat (WINDOW_LEN / 2) send_sample(10'd0);
    wait_idle();
    // takes effect at the end of the window already half filled
    write_reg(CFG_RAW_MODE, 8'h01);
    repeat (WINDOW_LEN / 2) send_sample(10'd1023);
    repeat (WINDOW_LEN) send_sample(10'd0);
    wait_idle();
    // only bit 0 of the raw mode write counts
    write_reg(CFG_RAW_MODE, 8'hFE);
    repeat (WINDOW_LEN) send_sample(10'd0);
    wait_idle();
  endtask

  // calibration at and just past both ends of the accepted ranges
  task automatic test_register_sweep();
    logic [CFG_W-1:0] slopes[8];
    logic [CFG_W-1:0] icpts[8];
    logic             raws[8];
    slopes = '{8'd0, 8'd255, 8'd159, 8'd160, 8'd180, 8'd181, 8'd173, 8'd170};
    icpts  = '{8'd0, 8'd255, 8'd64, 8'd65, 8'd75, 8'd76, 8'd68, 8'd70};
    raws   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
    for (int i = 0; i < 8; i++) begin
      write_reg(CFG_SLOPE, slopes[i]);
      write_reg(CFG_INTERCEPT, icpts[i]);
      write_reg(CFG_RAW_MODE, {CFG_W'($urandom_range(0, 127)) << 1} | CFG_W'(raws[i]));
      // the spare index must not disturb anything
      write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 255)));
      send_level_run(WINDOW_LEN);
      wait_idle();
    end
  endtask

  // random runs not aligned to windows, settings changed between phases
  task automatic test_random_traffic();
    int sent;
    int run_len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(4, 60);
      send_level_run(run_len);
      sent += run_len;
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        randomize_settings();
      end
    end
    wait_idle();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_back_pressure();
    src_gaps_on  = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    send_level_run(4 * WINDOW_LEN);
    // sender pauses here until every reading has drained
    wait_idle();
    src_gaps_on = 1'b1;
  endtask

  // a stretch with no idling on either side
  task automatic test_unthrottled_burst();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    randomize_settings();
    send_level_run(5 * WINDOW_LEN + 3);
    wait_idle();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin
    apply_reset();
    test_directed_windows();
    test_register_sweep();
    test_random_traffic();
    test_back_pressure();
    test_unthrottled_burst();
    wait_idle();
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* rf_power_sample_to_dbm_core.f */
rtl/rfpd_pkg.sv
rtl/rfpd_sample_if.sv
rtl/rfpd_reading_if.sv
rtl/rfpd_serial_div.sv
rtl/rf_power_sample_to_dbm_core.sv
verif/rf_power_sample_to_dbm_core_test.sv
